/* rtl/rup2x_pkg.sv */
// Shared types and constants of the 2x bilinear RGB upscaler.
package rup2x_pkg;

  localparam int MAX_WIDTH    = 1024;
  localparam int HEIGHT_LIMIT = 1024;
  localparam int COL_W        = $clog2(MAX_WIDTH);
  localparam int ROW_W        = $clog2(HEIGHT_LIMIT);
  localparam int CFG_W        = 11;
  localparam int COORD_W      = 11;
  localparam int CH_W         = 8;
  localparam int CFG_IDX_W    = 1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'b1;

  typedef struct packed {
    logic [CH_W-1:0] r;
    logic [CH_W-1:0] g;
    logic [CH_W-1:0] b;
  } rgb_t;

  // Effective last column and last row index, after clamping.
  typedef struct packed {
    logic [COL_W-1:0] last_col_idx;
    logic [ROW_W-1:0] last_row_idx;
  } cfg_t;

  // One source pixel together with its neighbours, handed to the emitter.
  typedef struct packed {
    rgb_t             cur;
    rgb_t             above;
    rgb_t             left_cur;
    rgb_t             left_prev;
    logic [COL_W-1:0] x;
    logic [ROW_W-1:0] y;
    logic             last_col;
    logic             last_row;
  } job_t;

endpackage

/* rtl/rup2x_if.sv */
// Stream channel interfaces for source pixels and result pixels.
interface rup2x_pix_if;
  import rup2x_pkg::*;
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] red_in;
  logic [CH_W-1:0] green_in;
  logic [CH_W-1:0] blue_in;

  modport source (output valid, output red_in, output green_in, output blue_in, input ready);
  modport sink   (input valid, input red_in, input green_in, input blue_in, output ready);
endinterface

interface rup2x_res_if;
  import rup2x_pkg::*;
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] out_x;
  logic [COORD_W-1:0] out_y;
  logic [CH_W-1:0]    red_out;
  logic [CH_W-1:0]    green_out;
  logic [CH_W-1:0]    blue_out;
  logic               frame_last;

  modport source (output valid, output out_x, output out_y, output red_out,
                  output green_out, output blue_out, output frame_last, input ready);
  modport sink   (input valid, input out_x, input out_y, input red_out,
                  input green_out, input blue_out, input frame_last, output ready);
endinterface

/* rtl/rgb_upscale_2x_linear.sv */
// Top level of the 2x bilinear RGB upscaler.
//
// Source pixels enter on pix_i in raster order, one beat per pixel; result
// pixels leave on res_o, one beat per output pixel, each with its output
// column and row and a mark on the final pixel of the frame. Both channels
// use valid/ready and a beat moves when both are high. Each source pixel
// yields between zero and sixteen result beats (four on average), because a
// 2x2 block is only produced once its right and lower neighbours have arrived.
// The emitter puts out one result beat per cycle while the receiver keeps
// ready high, and that single output port sets the sustained rate. The first
// result of a source pixel passes through the s1 holding stage, the emitter's
// job register and the result register.
// A second source pixel is taken while the first one's results still drain,
// and a waiting result register does not block the input side. When the
// receiver holds ready low the result beat and everything behind it hold,
// and the input side stops once its one holding stage is full.
// Reset clears the counters, left-pixel registers and handshake state and
// sets the size to 640 by 480; the line buffer is not cleared, as its row 0
// reads are unused. The user must write the size registers via cfg_we_i,
// cfg_idx_i and cfg_data_i only while the block is idle; it is not enforced.
module rgb_upscale_2x_linear (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  rup2x_pix_if.sink                       pix_i,
  rup2x_res_if.source                     res_o,
  input  logic                            cfg_we_i,
  input  logic [rup2x_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [rup2x_pkg::CFG_W-1:0]     cfg_data_i
);
  import rup2x_pkg::*;

  localparam logic [CFG_W-1:0] RESET_WIDTH  = CFG_W'(640);
  localparam logic [CFG_W-1:0] RESET_HEIGHT = CFG_W'(480);

  logic [CFG_W-1:0] width_q;
  logic [CFG_W-1:0] height_q;
  cfg_t             cfg;
  logic             job_valid;
  logic             job_take;
  job_t             job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= RESET_WIDTH;
      height_q <= RESET_HEIGHT;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_WIDTH) begin
        width_q <= cfg_data_i;
      end
      if (cfg_idx_i == REG_HEIGHT) begin
        height_q <= cfg_data_i;
      end
    end
  end

  // A size of zero behaves as one; sizes beyond the limits behave as the limit.
  always_comb begin
    logic [CFG_W-1:0] w_m1;
    logic [CFG_W-1:0] h_m1;
    w_m1 = width_q - CFG_W'(1);
    h_m1 = height_q - CFG_W'(1);
    if (width_q == '0) begin
      cfg.last_col_idx = '0;
    end else if (width_q > CFG_W'(MAX_WIDTH)) begin
      cfg.last_col_idx = COL_W'(MAX_WIDTH - 1);
    end else begin
      cfg.last_col_idx = w_m1[COL_W-1:0];
    end
    if (height_q == '0) begin
      cfg.last_row_idx = '0;
    end else if (height_q > CFG_W'(HEIGHT_LIMIT)) begin
      cfg.last_row_idx = ROW_W'(HEIGHT_LIMIT - 1);
    end else begin
      cfg.last_row_idx = h_m1[ROW_W-1:0];
    end
  end

  rup2x_fetch u_fetch (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .pix_i      (pix_i),
    .job_valid_o(job_valid),
    .job_o      (job),
    .job_take_i (job_take)
  );

  rup2x_emit u_emit (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_valid_i(job_valid),
    .job_i      (job),
    .job_take_o (job_take),
    .res_o      (res_o)
  );

endmodule

/* rtl/rup2x_ram.sv */
// Simple dual-port synchronous RAM with registered, read-first read data.
module rup2x_ram #(
  parameter int Depth = 1024,
  parameter int Width = 24
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/rup2x_fetch.sv */
// Input stage: raster counters, line buffer access and left-neighbour registers.
module rup2x_fetch (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rup2x_pkg::cfg_t   cfg_i,
  rup2x_pix_if.sink         pix_i,
  output logic              job_valid_o,
  output rup2x_pkg::job_t   job_o,
  input  logic              job_take_i
);
  import rup2x_pkg::*;

  logic             accept;
  logic             advance;
  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic             last_col, last_row;
  logic             s1_valid_q, s1_valid_d;
  rgb_t             s1_cur_q;
  logic [COL_W-1:0] s1_x_q;
  logic [ROW_W-1:0] s1_y_q;
  logic             s1_last_col_q, s1_last_row_q;
  rgb_t             left_cur_q, left_prev_q;
  rgb_t             pix_in;
  rgb_t             above;

  assign pix_in   = '{r: pix_i.red_in, g: pix_i.green_in, b: pix_i.blue_in};
  assign last_col = (col_q >= cfg_i.last_col_idx);
  assign last_row = (row_q >= cfg_i.last_row_idx);

  assign advance     = s1_valid_q && job_take_i;
  assign pix_i.ready = !s1_valid_q || job_take_i;
  assign accept      = pix_i.valid && pix_i.ready;

  // Read-first RAM: the stored row entry at this column is read and replaced in one edge.
  rup2x_ram #(
    .Depth(MAX_WIDTH),
    .Width($bits(rgb_t))
  ) u_line_buf (
    .clk_i  (clk_i),
    .we_i   (accept),
    .waddr_i(col_q),
    .wdata_i(pix_in),
    .re_i   (accept),
    .raddr_i(col_q),
    .rdata_o(above)
  );

  always_comb begin
    col_d      = col_q;
    row_d      = row_q;
    s1_valid_d = s1_valid_q;
    if (advance) begin
      s1_valid_d = 1'b0;
    end
    if (accept) begin
      s1_valid_d = 1'b1;
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_q + ROW_W'(1);
      end else begin
        col_d = col_q + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      s1_valid_q  <= 1'b0;
      left_cur_q  <= '0;
      left_prev_q <= '0;
    end else begin
      col_q      <= col_d;
      row_q      <= row_d;
      s1_valid_q <= s1_valid_d;
      if (advance) begin
        left_cur_q  <= s1_cur_q;
        left_prev_q <= above;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_cur_q      <= pix_in;
      s1_x_q        <= col_q;
      s1_y_q        <= row_q;
      s1_last_col_q <= last_col;
      s1_last_row_q <= last_row;
    end
  end

  // The RAM read data stays put until the next accepted beat, which is also when s1 moves on.
  assign job_valid_o = s1_valid_q;
  always_comb begin
    job_o.cur       = s1_cur_q;
    job_o.above     = above;
    job_o.left_cur  = left_cur_q;
    job_o.left_prev = left_prev_q;
    job_o.x         = s1_x_q;
    job_o.y         = s1_y_q;
    job_o.last_col  = s1_last_col_q;
    job_o.last_row  = s1_last_row_q;
  end

endmodule

/* rtl/rup2x_emit.sv */
// Output sequencer: walks the due 2x2 blocks of a job and drives the result register.
module rup2x_emit (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            job_valid_i,
  input  rup2x_pkg::job_t job_i,
  output logic            job_take_o,
  rup2x_res_if.source     res_o
);
  import rup2x_pkg::*;

  // Block slots in emission order.
  localparam logic [1:0] BLK_UP_LEFT = 2'd0;
  localparam logic [1:0] BLK_UP      = 2'd1;
  localparam logic [1:0] BLK_LEFT    = 2'd2;
  localparam logic [1:0] BLK_HERE    = 2'd3;
  localparam logic [1:0] PIX_BR      = 2'd3;

  function automatic logic [CH_W-1:0] avg2(input logic [CH_W-1:0] a, input logic [CH_W-1:0] b);
    logic [CH_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CH_W:1];
  endfunction

  function automatic logic [CH_W-1:0] avg4(input logic [CH_W-1:0] a, input logic [CH_W-1:0] b,
                                           input logic [CH_W-1:0] c, input logic [CH_W-1:0] d);
    logic [CH_W+1:0] s;
    s = {2'b0, a} + {2'b0, b} + {2'b0, c} + {2'b0, d};
    return s[CH_W+1:2];
  endfunction

  job_t             job_q;
  logic [3:0]       rem_q, rem_d;
  logic [1:0]       pix_q, pix_d;
  logic [1:0]       blk;
  logic [3:0]       blk_bit;
  logic [3:0]       new_mask;
  logic             busy, step, last_step, load;
  rgb_t             op_p, op_rt, op_lo, op_dg, px;
  logic [COL_W-1:0] bx;
  logic [ROW_W-1:0] by;
  logic             ov_q;

  assign new_mask[BLK_UP_LEFT] = (job_i.y != '0) && (job_i.x != '0);
  assign new_mask[BLK_UP]      = (job_i.y != '0) && job_i.last_col;
  assign new_mask[BLK_LEFT]    = job_i.last_row && (job_i.x != '0);
  assign new_mask[BLK_HERE]    = job_i.last_row && job_i.last_col;

  always_comb begin
    if (rem_q[0]) begin
      blk = BLK_UP_LEFT;
    end else if (rem_q[1]) begin
      blk = BLK_UP;
    end else if (rem_q[2]) begin
      blk = BLK_LEFT;
    end else begin
      blk = BLK_HERE;
    end
  end
  assign blk_bit = 4'b0001 << blk;

  assign busy       = (rem_q != '0);
  assign step       = busy && (!ov_q || res_o.ready);
  assign last_step  = step && (pix_q == PIX_BR) && ((rem_q & ~blk_bit) == '0);
  assign job_take_o = !busy || last_step;
  assign load       = job_valid_i && job_take_o;

  always_comb begin
    rem_d = rem_q;
    pix_d = pix_q;
    if (step) begin
      pix_d = pix_q + 2'd1;
      if (pix_q == PIX_BR) begin
        rem_d = rem_q & ~blk_bit;
      end
    end
    if (load) begin
      rem_d = new_mask;
      pix_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
      pix_q <= '0;
      ov_q  <= 1'b0;
    end else begin
      rem_q <= rem_d;
      pix_q <= pix_d;
      if (step) begin
        ov_q <= 1'b1;
      end else if (res_o.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      job_q <= job_i;
    end
  end

  // Operands of the current block: top-left pixel, right, lower and diagonal neighbours.
  always_comb begin
    case (blk)
      BLK_UP_LEFT: begin
        op_p  = job_q.left_prev;
        op_rt = job_q.above;
        op_lo = job_q.left_cur;
        op_dg = job_q.cur;
        bx    = job_q.x - COL_W'(1);
        by    = job_q.y - ROW_W'(1);
      end
      BLK_UP: begin
        op_p  = job_q.above;
        op_rt = job_q.above;
        op_lo = job_q.cur;
        op_dg = job_q.cur;
        bx    = job_q.x;
        by    = job_q.y - ROW_W'(1);
      end
      BLK_LEFT: begin
        op_p  = job_q.left_cur;
        op_rt = job_q.cur;
        op_lo = job_q.left_cur;
        op_dg = job_q.cur;
        bx    = job_q.x - COL_W'(1);
        by    = job_q.y;
      end
      default: begin
        op_p  = job_q.cur;
        op_rt = job_q.cur;
        op_lo = job_q.cur;
        op_dg = job_q.cur;
        bx    = job_q.x;
        by    = job_q.y;
      end
    endcase
  end

  always_comb begin
    case (pix_q)
      2'd0: px = op_p;
      2'd1: px = '{r: avg2(op_p.r, op_rt.r), g: avg2(op_p.g, op_rt.g), b: avg2(op_p.b, op_rt.b)};
      2'd2: px = '{r: avg2(op_p.r, op_lo.r), g: avg2(op_p.g, op_lo.g), b: avg2(op_p.b, op_lo.b)};
      default: begin
        px = '{r: avg4(op_p.r, op_rt.r, op_lo.r, op_dg.r),
               g: avg4(op_p.g, op_rt.g, op_lo.g, op_dg.g),
               b: avg4(op_p.b, op_rt.b, op_lo.b, op_dg.b)};
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_o.out_x      <= COORD_W'({bx, pix_q[0]});
      res_o.out_y      <= COORD_W'({by, pix_q[1]});
      res_o.red_out    <= px.r;
      res_o.green_out  <= px.g;
      res_o.blue_out   <= px.b;
      res_o.frame_last <= (blk == BLK_HERE) && (pix_q == PIX_BR);
    end
  end

  assign res_o.valid = ov_q;

endmodule
